[design/bksp_pkg.sv]
// Shared types, codes and lookup functions for the base-k symbol packer.
package bksp_pkg;

	// Width of the unpack character counter.
	localparam int MAX_LENGTH_BITS = 16;
	localparam int SYM_W           = 8;
	localparam int NUM_SYMS        = 6;
	localparam int ALPHA_W         = SYM_W * NUM_SYMS;

	localparam logic DIR_PACK   = 1'b0;
	localparam logic DIR_UNPACK = 1'b1;

	typedef logic [MAX_LENGTH_BITS-1:0] len_t;

	typedef enum logic [1:0] {
		REG_DIRECTION       = 2'd0,
		REG_ALPHABET_SIZE   = 2'd1,
		REG_ALPHABET_CHARS  = 2'd2,
		REG_ORIGINAL_LENGTH = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_PAD    = 2'd1,
		ST_UNPACK = 2'd2
	} state_t;

	typedef struct packed {
		logic acc;           // fold input digit into group
		logic pad;           // append one zero digit
		logic pack_out;      // emit group byte, clear group
		logic unpack_load;   // take byte, start digit split
		logic unpack_emit;   // emit next digit character
		logic unpack_finish; // item done, clear count on message end
	} bksp_cmd_t;

	typedef struct packed {
		logic unpack_mode;
		logic pack_close;
		logic pad_done;
		logic can_emit;
		logic last_digit;
		logic out_free;
	} bksp_status_t;

	// Sizes below 2 act as 2, above 6 as 6.
	function automatic logic [2:0] eff_base(input logic [2:0] size);
		logic [2:0] b;
		b = size;
		if (size < 3'd2) begin
			b = 3'd2;
		end else if (size > 3'd6) begin
			b = 3'd6;
		end
		return b;
	endfunction

	// Digits per packed byte.
	function automatic logic [2:0] group_len(input logic [2:0] base);
		logic [2:0] r;
		case (base)
			3'd2: r = 3'd7;
			3'd3: r = 3'd5;
			default: r = 3'd3;
		endcase
		return r;
	endfunction

	// base ** group_len, the range of one group.
	function automatic logic [7:0] group_span(input logic [2:0] base);
		logic [7:0] s;
		case (base)
			3'd2: s = 8'd128;
			3'd3: s = 8'd243;
			3'd4: s = 8'd64;
			3'd5: s = 8'd125;
			default: s = 8'd216;
		endcase
		return s;
	endfunction

	function automatic logic [SYM_W-1:0] symbol_at(input logic [ALPHA_W-1:0] chars,
			input logic [2:0] idx);
		logic [SYM_W-1:0] s;
		s = '0;
		for (int i = 0; i < NUM_SYMS; i++) begin
			if (idx == 3'(i)) begin
				s = chars[i*SYM_W +: SYM_W];
			end
		end
		return s;
	endfunction

endpackage

[design/base_k_symbol_packer.sv]
// Top level of the base-k symbol packer: stream ports, config port, controller and datapath.
//
//  channel   handshake                      payload
//  s_axis    s_axis_tvalid / s_axis_tready  tdata = data_byte, tlast = msg_end
//  m_axis    m_axis_tvalid / m_axis_tready  tdata = out_byte, tlast = run_last,
//                                           tuser = bad_symbol
//  cfg       cfg_we (no wait)               cfg_index, cfg_wdata
//
// Pack: a request that does not close a group only folds its digit into the group. A closing
// request moves on to the pad state, which appends zero pad digits until the group is full
// and then loads the output register; the pad loop runs one multiply by the base per cycle.
// Unpack: the byte is loaded, then the digit splitter gives one character per cycle while the
// output is free (up to 7); a finish step follows if the length limit cuts the group short.
// One request is in flight at a time; s_axis_tready is high only while idle.
// A finished result waits in the output register; m_axis_tready low stalls the
// sequencer only when it has a new result to load. Reset is asynchronous, active
// low, clears all control state and restores register defaults; no clearing pass.
module base_k_symbol_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [bksp_pkg::ALPHA_W-1:0]  cfg_wdata,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
	input  logic                          s_axis_tlast,  // msg_end
	// output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [7:0] out_byte
	output logic                          m_axis_tlast,  // run_last
	output logic                          m_axis_tuser   // [0] bad_symbol
);

	bksp_pkg::bksp_cmd_t    cmd;
	bksp_pkg::bksp_status_t status;

	// sequencer: decides which datapath step runs each cycle
	bksp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: config, group accumulator, digit splitter, output register
	bksp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_byte   (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_bad   (m_axis_tuser)
	);

endmodule

[design/bksp_ctrl.sv]
// Sequencer for the base-k symbol packer: accept, pad, emit.
module bksp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bksp_pkg::bksp_status_t status,
	output bksp_pkg::bksp_cmd_t    cmd
);

	bksp_pkg::state_t state_q;
	bksp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bksp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			bksp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (status.unpack_mode) begin
						cmd.unpack_load = 1'b1;
						state_d         = bksp_pkg::ST_UNPACK;
					end else begin
						cmd.acc = 1'b1;
						if (status.pack_close) begin
							state_d = bksp_pkg::ST_PAD;
						end
					end
				end
			end
			bksp_pkg::ST_PAD: begin
				if (!status.pad_done) begin
					cmd.pad = 1'b1;
				end else if (status.out_free) begin
					cmd.pack_out = 1'b1;
					state_d      = bksp_pkg::ST_IDLE;
				end
			end
			bksp_pkg::ST_UNPACK: begin
				if (!status.can_emit) begin
					cmd.unpack_finish = 1'b1;
					state_d           = bksp_pkg::ST_IDLE;
				end else if (status.out_free) begin
					cmd.unpack_emit = 1'b1;
					if (status.last_digit) begin
						cmd.unpack_finish = 1'b1;
						state_d           = bksp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bksp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[design/bksp_dp.sv]
// Datapath for the base-k symbol packer: config, group state, digit split, output register.
module bksp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [bksp_pkg::ALPHA_W-1:0]  cfg_wdata,
	input  logic [7:0]                    in_byte,
	input  logic                          in_end,
	input  bksp_pkg::bksp_cmd_t           cmd,
	output bksp_pkg::bksp_status_t        status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          out_last,
	output logic                          out_bad
);

	// config
	logic                         direction_q;
	logic [2:0]                   alpha_size_q;
	logic [bksp_pkg::ALPHA_W-1:0] alpha_chars_q;
	logic [15:0]                  orig_len_q;

	// pack state
	logic [7:0] group_value_q;
	logic [2:0] digits_q;
	logic       group_bad_q;

	// unpack state
	bksp_pkg::len_t chars_q;
	logic [7:0]     rem_q;
	logic [2:0]     idx_q;
	logic           end_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_bad_q;

	logic [2:0]  base;
	logic [2:0]  ratio;
	logic [7:0]  span;
	logic [2:0]  in_digit;
	logic        in_found;
	logic [10:0] acc_prod;
	logic [10:0] pad_prod;
	logic [2:0]  digits_inc;
	logic        bad_next;
	logic [7:0]  unp_byte;
	logic [9:0]  red;
	logic [10:0] shifted;
	logic [10:0] emit_rem;
	logic [2:0]  emit_digit;
	bksp_pkg::len_t limit;
	bksp_pkg::len_t chars_inc;
	logic        emit_last;
	logic        out_load;

	assign base  = bksp_pkg::eff_base(alpha_size_q);
	assign ratio = bksp_pkg::group_len(base);
	assign span  = bksp_pkg::group_span(base);

	// Character to digit: lowest matching index wins; zero maps to digit 0.
	always_comb begin
		in_digit = '0;
		in_found = 1'b0;
		for (int i = 0; i < bksp_pkg::NUM_SYMS; i++) begin
			if (!in_found && (in_byte != 8'd0) && (3'(i) < base) &&
					(alpha_chars_q[i*bksp_pkg::SYM_W +: bksp_pkg::SYM_W] == in_byte)) begin
				in_digit = 3'(i);
				in_found = 1'b1;
			end
		end
	end

	assign acc_prod   = 11'(group_value_q) * 11'(base) + 11'(in_digit);
	assign pad_prod   = 11'(group_value_q) * 11'(base);
	assign digits_inc = digits_q + 3'd1;
	assign bad_next   = group_bad_q | ((in_byte != 8'd0) & ~in_found);

	// Byte minus one, reduced modulo the group span (only low digits survive).
	assign unp_byte = in_byte - 8'd1;
	always_comb begin
		red = 10'(unp_byte);
		for (int j = 1; j <= 3; j++) begin
			if (10'(unp_byte) >= 10'(j) * 10'(span)) begin
				red = 10'(unp_byte) - 10'(j) * 10'(span);
			end
		end
	end

	// Most significant digit first: digit = floor(rem * base / span).
	assign shifted = 11'(rem_q) * 11'(base);
	always_comb begin
		emit_digit = '0;
		emit_rem   = shifted;
		for (int j = 1; j <= 5; j++) begin
			if (shifted >= 11'(j) * 11'(span)) begin
				emit_digit = 3'(j);
				emit_rem   = shifted - 11'(j) * 11'(span);
			end
		end
	end

	assign limit     = bksp_pkg::len_t'(orig_len_q);
	assign chars_inc = chars_q + bksp_pkg::len_t'(1);
	assign emit_last = (idx_q == ratio - 3'd1) || (chars_inc >= limit);
	assign out_load  = cmd.pack_out | cmd.unpack_emit;

	assign status.unpack_mode = (direction_q == bksp_pkg::DIR_UNPACK);
	assign status.pack_close  = (digits_inc >= ratio) || in_end;
	assign status.pad_done    = (digits_q >= ratio);
	assign status.can_emit    = (chars_q < limit);
	assign status.last_digit  = (idx_q == ratio - 3'd1);
	assign status.out_free    = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q   <= bksp_pkg::DIR_PACK;
			alpha_size_q  <= 3'd4;
			alpha_chars_q <= '0;
			orig_len_q    <= '0;
		end else if (cfg_we) begin
			case (bksp_pkg::reg_idx_t'(cfg_index))
				bksp_pkg::REG_DIRECTION:       direction_q   <= cfg_wdata[0];
				bksp_pkg::REG_ALPHABET_SIZE:   alpha_size_q  <= cfg_wdata[2:0];
				bksp_pkg::REG_ALPHABET_CHARS:  alpha_chars_q <= cfg_wdata;
				bksp_pkg::REG_ORIGINAL_LENGTH: orig_len_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_value_q <= '0;
			digits_q      <= '0;
			group_bad_q   <= 1'b0;
		end else if (cmd.acc) begin
			group_value_q <= acc_prod[7:0];
			digits_q      <= digits_inc;
			group_bad_q   <= bad_next;
		end else if (cmd.pad) begin
			group_value_q <= pad_prod[7:0];
			digits_q      <= digits_inc;
		end else if (cmd.pack_out) begin
			group_value_q <= '0;
			digits_q      <= '0;
			group_bad_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
		end else begin
			if (cmd.unpack_load) begin
				idx_q <= '0;
				end_q <= in_end;
			end else if (cmd.unpack_emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (cmd.unpack_finish && end_q) begin
				chars_q <= '0;
			end else if (cmd.unpack_emit && (chars_q != '1)) begin
				chars_q <= chars_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.unpack_load) begin
			rem_q <= red[7:0];
		end else if (cmd.unpack_emit) begin
			rem_q <= emit_rem[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack_out) begin
			out_byte_q <= group_value_q + 8'd1;
			out_last_q <= 1'b1;
			out_bad_q  <= group_bad_q;
		end else if (cmd.unpack_emit) begin
			out_byte_q <= bksp_pkg::symbol_at(alpha_chars_q, emit_digit);
			out_last_q <= emit_last;
			out_bad_q  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

`ifndef SYNTHESIS
	// Never overwrite a result that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("bksp_dp: output register overwritten while stalled");

	// Emitting a group leaves a clean group behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pack_out |=> (digits_q == 3'd0) && (group_value_q == 8'd0) && !group_bad_q)
		else $error("bksp_dp: group state not cleared after emit");

	// Each emitted character advances the count by one, or it sits at its ceiling.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.unpack_emit && !cmd.unpack_finish) |=>
			(chars_q == $past(chars_inc)) || ($past(chars_q) == '1))
		else $error("bksp_dp: character count did not advance");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for the base-k symbol packer: directed table, then random phases.
`timescale 1ns / 100ps

module tb;

	localparam int LIMIT_CYCLES  = 500000; // hard stop, far above the slowest legal run
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES    = 20;
	localparam int LONG_HOLD     = 300;    // receiver back-pressure stretch
	localparam int TARGET_ITEMS  = 270;

	// alphabets, symbol 0 in the low byte
	localparam logic [bksp_pkg::ALPHA_W-1:0] ALPHA_ACGU = 48'h0000_5547_4341; // "ACGU"
	localparam logic [bksp_pkg::ALPHA_W-1:0] ALPHA_BIN  = 48'h0000_0000_3130; // "01"
	localparam logic [bksp_pkg::ALPHA_W-1:0] ALPHA_ABC  = 48'h0000_0063_6261; // "abc"
	localparam logic [bksp_pkg::ALPHA_W-1:0] ALPHA_HEX6 = 48'h4645_4443_4241; // "ABCDEF"
	localparam logic [bksp_pkg::ALPHA_W-1:0] ALPHA_ABAB = 48'h0000_4241_4241; // "ABAB", repeats

	// one expected output beat
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       bad;
	} out_rec_t;

	// one row of the directed table: either a register setting or a request
	typedef struct {
		bit                           is_cfg;
		logic                         dir;
		logic [2:0]                   size;
		logic [bksp_pkg::ALPHA_W-1:0] chars;
		bksp_pkg::len_t               len;
		logic [7:0]                   data;
		logic                         last;
		bit                           typed;   // expected beat written into the row
		logic [7:0]                   t_byte;
		logic                         t_bad;
	} step_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         cfg_we        = 1'b0;
	logic [1:0]                   cfg_index     = bksp_pkg::REG_DIRECTION;
	logic [bksp_pkg::ALPHA_W-1:0] cfg_wdata     = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [7:0]                   s_axis_tdata  = 8'h00; // [7:0] data_byte
	logic                         s_axis_tlast  = 1'b0;  // msg_end
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [7:0]                   m_axis_tdata;          // [7:0] out_byte
	logic                         m_axis_tlast;          // run_last
	logic                         m_axis_tuser;          // [0] bad_symbol

	// predictor copy of the registers
	logic                         cf_dir   = bksp_pkg::DIR_PACK;
	logic [2:0]                   cf_size  = 3'd4;
	logic [bksp_pkg::ALPHA_W-1:0] cf_chars = '0;
	bksp_pkg::len_t               cf_len   = '0;

	// predictor copy of the state
	logic [7:0]     grp_value  = 8'h00;
	logic [2:0]     grp_digits = 3'd0;
	logic           grp_bad    = 1'b0;
	bksp_pkg::len_t chars_out  = '0;

	out_rec_t pending_bytes[$];
	step_t    plan[$];

	int cycle_count     = 0;
	int mismatches      = 0;
	int results_checked = 0;
	int bad_seen        = 0;
	int items_sent      = 0;
	int pack_items      = 0;
	int unpack_items    = 0;
	int settings_used   = 0;
	int tx_max_gap      = 15;
	int rx_max_gap      = 15;
	int hold_asks       = 0;   // written by the stimulus only
	int holds_done      = 0;   // written by the receiver only

	base_k_symbol_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycle_count,
				pending_bytes.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// size 0/1 behaves as 2, size 7 as 6
	function automatic int radix_of(logic [2:0] size);
		if (size < 3'd2) return 2;
		if (size > 3'd6) return 6;
		return int'(size);
	endfunction

	function automatic int digits_per_byte(int k);
		if (k == 2) return 7;
		if (k == 3) return 5;
		return 3;
	endfunction

	// Works out the beats one accepted request produces, appends them to
	// pending_bytes and returns how many there were.
	function automatic int predict_symbols(logic [7:0] b, logic e);
		int         k;
		int         ratio;
		int         d;
		int         n;
		bit         found;
		logic [7:0] p;
		logic [7:0] dig [7];
		k     = radix_of(cf_size);
		ratio = digits_per_byte(k);
		n     = 0;
		if (cf_dir == bksp_pkg::DIR_PACK) begin
			// zero char is digit 0 and never flagged; unknown char is digit 0, flagged
			d = 0;
			if (b != 8'h00) begin
				found = 1'b0;
				for (int i = 0; i < k; i++) begin
					if (!found && cf_chars[8*i +: 8] == b) begin
						d     = i;
						found = 1'b1;
					end
				end
				if (!found) grp_bad = 1'b1;
			end
			grp_value  = 8'(grp_value * k + d);
			grp_digits = grp_digits + 3'd1;
			// the group closes against the ratio in force now, even after a size change
			if (int'(grp_digits) >= ratio || e) begin
				while (int'(grp_digits) < ratio) begin
					grp_value  = 8'(grp_value * k);
					grp_digits = grp_digits + 3'd1;
				end
				pending_bytes.push_back('{8'(grp_value + 8'd1), 1'b1, grp_bad});
				n          = 1;
				grp_value  = 8'h00;
				grp_digits = 3'd0;
				grp_bad    = 1'b0;
			end
		end else begin
			// byte 0 wraps to 255; only the low ratio digits survive
			p = b - 8'd1;
			for (int j = ratio - 1; j >= 0; j--) begin
				dig[j] = 8'(p % k);
				p      = 8'(p / k);
			end
			for (int j = 0; j < ratio; j++) begin
				if (chars_out < cf_len) begin
					pending_bytes.push_back('{cf_chars[8*dig[j] +: 8], 1'b0, 1'b0});
					n++;
					if (chars_out != '1) chars_out = chars_out + 1'b1;
				end
			end
			if (n > 0) pending_bytes[pending_bytes.size()-1].last = 1'b1;
			if (e) chars_out = '0;
		end
		return n;
	endfunction

	function automatic step_t req(logic [7:0] d, logic e);
		step_t s;
		s        = '{default: 0};
		s.data   = d;
		s.last   = e;
		return s;
	endfunction

	function automatic step_t req_known(logic [7:0] d, logic e, logic [7:0] b, logic bad);
		step_t s;
		s        = req(d, e);
		s.typed  = 1'b1;
		s.t_byte = b;
		s.t_bad  = bad;
		return s;
	endfunction

	function automatic step_t setting(logic dir, logic [2:0] size,
			logic [bksp_pkg::ALPHA_W-1:0] chars, bksp_pkg::len_t len);
		step_t s;
		s        = '{default: 0};
		s.is_cfg = 1'b1;
		s.dir    = dir;
		s.size   = size;
		s.chars  = chars;
		s.len    = len;
		return s;
	endfunction

	// six random symbols, now and then a repeat of an earlier one or a zero
	function automatic logic [bksp_pkg::ALPHA_W-1:0] random_alphabet();
		logic [bksp_pkg::ALPHA_W-1:0] a;
		logic [7:0]                   c;
		int                           src;
		a = '0;
		for (int i = 0; i < bksp_pkg::NUM_SYMS; i++) begin
			c = 8'($urandom_range(1, 255));
			if (i > 0 && $urandom_range(0, 7) == 0) begin
				src = $urandom_range(0, i - 1);
				c   = a[8*src +: 8];
			end else if ($urandom_range(0, 15) == 0) begin
				c = 8'h00;
			end
			a[8*i +: 8] = c;
		end
		return a;
	endfunction

	function automatic logic [7:0] random_symbol();
		int r;
		int idx;
		r = $urandom_range(0, 9);
		if (r < 8) begin
			idx = $urandom_range(0, radix_of(cf_size) - 1);
			return cf_chars[8*idx +: 8];
		end
		if (r == 8) return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly bytes a packer can produce (1..k**ratio), some anything
	function automatic logic [7:0] random_packed();
		int k;
		int span;
		k    = radix_of(cf_size);
		span = 1;
		for (int i = 0; i < digits_per_byte(k); i++) span = span * k;
		if ($urandom_range(0, 9) < 7) return 8'($urandom_range(1, span));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic log_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("[%0t] mismatch in %s: got 0x%02h, expected 0x%02h (beat %0d)", $time, what,
			got, want, results_checked);
		mismatches++;
	endtask

	// Receiver: random stall before each beat, one long hold when asked.
	initial begin
		int       gap;
		out_rec_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done < hold_asks) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else begin
				gap = $urandom_range(0, rx_max_gap);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid && holds_done >= hold_asks);
			if (m_axis_tvalid) begin
				results_checked++;
				if (m_axis_tuser === 1'b1) bad_seen++;
				if (pending_bytes.size() == 0) begin
					log_mismatch("unexpected beat", m_axis_tdata, 8'h00);
				end else begin
					want = pending_bytes.pop_front();
					if (m_axis_tdata !== want.ch) log_mismatch("out_byte", m_axis_tdata, want.ch);
					if (m_axis_tlast !== want.last)
						log_mismatch("run_last", 8'(m_axis_tlast), 8'(want.last));
					if (m_axis_tuser !== want.bad)
						log_mismatch("bad_symbol", 8'(m_axis_tuser), 8'(want.bad));
				end
			end
		end
	end

	// Presents one request after a random gap; returns once it is taken,
	// with tvalid left high so a back-to-back request needs no second write.
	task automatic offer(logic [7:0] d, logic e, output int made);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= e;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (cf_dir == bksp_pkg::DIR_PACK) pack_items++;
		else unpack_items++;
		made = predict_symbols(d, e);
	endtask

	// Drop tvalid, wait for every expected beat, then let the block go quiet
	// (a request that yields nothing may still be busy).
	task automatic drain(int extra);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// writes all four registers back to back, only while idle
	task automatic load_settings(logic dir, logic [2:0] size,
			logic [bksp_pkg::ALPHA_W-1:0] chars, bksp_pkg::len_t len);
		cfg_we    <= 1'b1;
		cfg_index <= bksp_pkg::REG_DIRECTION;
		cfg_wdata <= bksp_pkg::ALPHA_W'(dir);
		@(posedge clk);
		cfg_index <= bksp_pkg::REG_ALPHABET_SIZE;
		cfg_wdata <= bksp_pkg::ALPHA_W'(size);
		@(posedge clk);
		cfg_index <= bksp_pkg::REG_ALPHABET_CHARS;
		cfg_wdata <= chars;
		@(posedge clk);
		cfg_index <= bksp_pkg::REG_ORIGINAL_LENGTH;
		cfg_wdata <= bksp_pkg::ALPHA_W'(len);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cf_dir   = dir;
		cf_size  = size;
		cf_chars = chars;
		cf_len   = len;
		settings_used++;
	endtask

	// Stimulus: directed table, then random phases of whole messages.
	initial begin
		int             made;
		int             phase;
		int             phase_items;
		int             in_phase;
		int             msg_len;
		int             pick;
		logic           dir;
		logic [2:0]     size;
		bksp_pkg::len_t len;

		// defaults after reset: pack, size 4, all-zero alphabet
		plan.push_back(req_known(8'h00, 1'b1, 8'h01, 1'b0)); // zero char, not flagged
		plan.push_back(req_known(8'h41, 1'b1, 8'h01, 1'b1)); // unknown char
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd4, ALPHA_ACGU, '0));
		plan.push_back(req(8'h55, 1'b0));
		plan.push_back(req(8'h55, 1'b0));
		plan.push_back(req_known(8'h55, 1'b0, 8'h40, 1'b0)); // UUU = 63
		plan.push_back(req_known(8'h43, 1'b1, 8'h11, 1'b0)); // C, padded twice
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd3, ALPHA_ABC, '0));
		repeat (4) plan.push_back(req(8'h63, 1'b0));
		plan.push_back(req_known(8'h63, 1'b0, 8'hF3, 1'b0)); // largest packed byte
		// size change mid-group: two base-6 digits, then five base-2 digits (wraps)
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd6, ALPHA_HEX6, '0));
		plan.push_back(req(8'h46, 1'b0));
		plan.push_back(req(8'h46, 1'b0));
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd2, ALPHA_HEX6, '0));
		repeat (5) plan.push_back(req(8'h42, 1'b0));
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd4, ALPHA_ABAB, '0));
		plan.push_back(req_known(8'h42, 1'b1, 8'h11, 1'b0)); // repeat: lowest index wins
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd7, ALPHA_HEX6, '0));
		plan.push_back(req_known(8'h46, 1'b1, 8'hB5, 1'b0)); // size 7 acts as 6
		plan.push_back(setting(bksp_pkg::DIR_PACK, 3'd0, ALPHA_BIN, '0));
		plan.push_back(req_known(8'h31, 1'b1, 8'h41, 1'b0)); // size 0 acts as 2
		// unpack, trimmed after seven characters; byte 0 wraps to 255
		plan.push_back(setting(bksp_pkg::DIR_UNPACK, 3'd4, ALPHA_ACGU, 16'd7));
		plan.push_back(req(8'h40, 1'b0));
		plan.push_back(req(8'h00, 1'b0));
		plan.push_back(req(8'h01, 1'b1));
		// length 0: no beats
		plan.push_back(setting(bksp_pkg::DIR_UNPACK, 3'd6, ALPHA_HEX6, '0));
		plan.push_back(req(8'hFF, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain(SETTLE_CYCLES);
				load_settings(plan[i].dir, plan[i].size, plan[i].chars, plan[i].len);
			end else begin
				offer(plan[i].data, plan[i].last, made);
				if (plan[i].typed) begin
					repeat (made) void'(pending_bytes.pop_back());
					pending_bytes.push_back('{plan[i].t_byte, 1'b1, plan[i].t_bad});
				end
			end
		end

		// Random phases alternate direction; idling pattern rotates so that
		// some phases run with no gaps at all on one or both sides.
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			drain(SETTLE_CYCLES);
			dir  = (phase % 2 == 1) ? bksp_pkg::DIR_UNPACK : bksp_pkg::DIR_PACK;
			size = 3'($urandom_range(0, 7));
			pick = $urandom_range(0, 9);
			if (pick == 0) len = '0;
			else if (pick == 1) len = '1;
			else len = bksp_pkg::len_t'($urandom_range(1, 40));
			if (phase == 1) len = '1; // hold phase needs plenty of output
			load_settings(dir, size, random_alphabet(), len);
			case (phase % 4)
				0: begin tx_max_gap = 15; rx_max_gap = 15; end
				1: begin tx_max_gap = 0;  rx_max_gap = 0;  end
				2: begin tx_max_gap = 15; rx_max_gap = 0;  end
				default: begin tx_max_gap = 0; rx_max_gap = 15; end
			endcase
			// receiver goes quiet while requests keep coming: input must stall
			if (phase == 1) hold_asks++;
			phase_items = $urandom_range(16, 26);
			in_phase    = 0;
			while (in_phase < phase_items) begin
				msg_len = (dir == bksp_pkg::DIR_PACK) ? $urandom_range(1, 12) :
					$urandom_range(1, 6);
				for (int j = 0; j < msg_len; j++) begin
					offer((dir == bksp_pkg::DIR_PACK) ? random_symbol() : random_packed(),
						j == msg_len - 1, made);
					in_phase++;
				end
				// sender waits out every expected beat once, mid-phase
				if (phase == 3 && in_phase == msg_len) drain(0);
			end
			phase++;
		end

		drain(END_CYCLES);
		$display("Covered %0d requests (%0d pack, %0d unpack) over %0d register settings,",
			items_sent, pack_items, unpack_items, settings_used);
		$display("  %0d beats checked, %0d flagged bad, %0d long receiver hold(s).",
			results_checked, bad_seen, holds_done);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
